// ===== sv/phhd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package phhd_pkg;

    // Fixed widths of the port fields.
    localparam int TIME_PORT_W = 63;
    localparam int CFG_W       = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int FACETS      = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_HOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_HOLD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_TIMEOUT = 2'd2;

    localparam logic [CFG_W-1:0] STALE_RESET = 40'd1000000000;

    typedef enum logic [1:0] {
        OUT_APPEND  = 2'd0,
        OUT_REPLACE = 2'd1,
        OUT_REJECT  = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_UNKNOWN  = 2'd0,
        ST_INACTIVE = 2'd1,
        ST_ACTIVE   = 2'd2
    } t_fstate;

    // Classified item handed from the front part to the back part.
    // Bit f of beyond and inside_exit belongs to facet f (body, left, right).
    typedef struct packed {
        t_outcome          outcome;
        logic              stale;
        logic [FACETS-1:0] beyond;
        logic [FACETS-1:0] inside_exit;
    } t_cmd;

endpackage

`default_nettype wire

// ===== sv/phhd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module phhd_front #(
    parameter int TIME_WIDTH = 63
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    input  wire                              i_full,
    input  wire [TIME_WIDTH-1:0]             i_time,
    input  wire [phhd_pkg::FACETS-1:0]       i_beyond,
    input  wire [phhd_pkg::FACETS-1:0]       i_inside,
    input  wire [phhd_pkg::CFG_W-1:0]        i_stale_timeout,
    output logic                             o_push,
    output logic [TIME_WIDTH-1:0]            o_time,
    output phhd_pkg::t_cmd                   o_cmd
);

    localparam int CMP_W = (TIME_WIDTH > phhd_pkg::CFG_W) ? TIME_WIDTH : phhd_pkg::CFG_W;

    logic [TIME_WIDTH-1:0] r_last;
    logic [TIME_WIDTH-1:0] r_prior;

    logic                  is_equal;
    logic [TIME_WIDTH-1:0] base_time;
    logic [TIME_WIDTH-1:0] gap;
    phhd_pkg::t_outcome    outcome;

    assign o_push   = i_valid & ~i_full;
    assign o_time   = i_time;
    assign is_equal = (i_time == r_last);

    always_comb begin
        if ((i_time == '0) || (i_time < r_last)) begin
            outcome = phhd_pkg::OUT_REJECT;
        end else if (is_equal) begin
            outcome = phhd_pkg::OUT_REPLACE;
        end else begin
            outcome = phhd_pkg::OUT_APPEND;
        end
    end

    // A replacement measures its gap from the sample before the replaced one.
    assign base_time = is_equal ? r_prior : r_last;
    assign gap       = i_time - base_time;

    always_comb begin
        o_cmd.outcome     = outcome;
        o_cmd.stale       = (base_time != '0) &&
                            (CMP_W'(gap) > CMP_W'(i_stale_timeout));
        o_cmd.beyond      = i_beyond;
        o_cmd.inside_exit = i_inside;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_prior <= '0;
        end else if (o_push && (outcome == phhd_pkg::OUT_APPEND)) begin
            r_prior <= r_last;
            r_last  <= i_time;
        end
    end

endmodule

`default_nettype wire

// ===== sv/phhd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module phhd_queue #(
    parameter int W     = 72,
    parameter int DEPTH = 2
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire          i_pop,
    input  wire [W-1:0]  i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/phhd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module phhd_back #(
    parameter int TIME_WIDTH = 63
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    input  wire [TIME_WIDTH-1:0]          i_time,
    input  phhd_pkg::t_cmd                i_cmd,
    input  wire [phhd_pkg::CFG_W-1:0]     i_enter_hold,
    input  wire [phhd_pkg::CFG_W-1:0]     i_exit_hold,
    input  wire                           i_stall,
    output logic                          o_pop,
    output logic                          o_valid,
    output phhd_pkg::t_outcome            o_outcome,
    output phhd_pkg::t_fstate             o_state [phhd_pkg::FACETS],
    output logic [TIME_WIDTH-1:0]         o_since [phhd_pkg::FACETS],
    output phhd_pkg::t_fstate             o_agg,
    output logic [TIME_WIDTH-1:0]         o_agg_since,
    output logic                          o_changed
);

    localparam int NF    = phhd_pkg::FACETS;
    localparam int CMP_W = (TIME_WIDTH > phhd_pkg::CFG_W) ? TIME_WIDTH : phhd_pkg::CFG_W;

    // Current machine and the copy taken before the last appended sample.
    phhd_pkg::t_fstate     r_val [NF];
    logic [TIME_WIDTH-1:0] r_since [NF];
    logic [TIME_WIDTH-1:0] r_es [NF];
    logic [TIME_WIDTH-1:0] r_xs [NF];
    phhd_pkg::t_fstate     r_agg;
    logic [TIME_WIDTH-1:0] r_agg_since;
    phhd_pkg::t_fstate     r_p_val [NF];
    logic [TIME_WIDTH-1:0] r_p_since [NF];
    logic [TIME_WIDTH-1:0] r_p_es [NF];
    logic [TIME_WIDTH-1:0] r_p_xs [NF];
    phhd_pkg::t_fstate     r_p_agg;
    logic [TIME_WIDTH-1:0] r_p_agg_since;

    // Output register.
    logic                  r_out_valid;
    phhd_pkg::t_outcome    r_out_outcome;
    phhd_pkg::t_fstate     r_out_state [NF];
    logic [TIME_WIDTH-1:0] r_out_since [NF];
    phhd_pkg::t_fstate     r_out_agg;
    logic [TIME_WIDTH-1:0] r_out_agg_since;
    logic                  r_out_changed;

    // Step datapath.
    logic                  use_prior;
    phhd_pkg::t_fstate     b_val [NF];
    logic [TIME_WIDTH-1:0] b_since [NF];
    logic [TIME_WIDTH-1:0] b_es [NF];
    logic [TIME_WIDTH-1:0] b_xs [NF];
    phhd_pkg::t_fstate     b_agg;
    logic [TIME_WIDTH-1:0] b_agg_since;
    logic                  act [NF];
    logic [TIME_WIDTH-1:0] run [NF];
    logic [TIME_WIDTH-1:0] st [NF];
    logic [TIME_WIDTH-1:0] diff [NF];
    logic [CMP_W-1:0]      hold [NF];
    logic [CMP_W-1:0]      sum [NF];
    logic                  hit [NF];
    phhd_pkg::t_fstate     n_val [NF];
    logic [TIME_WIDTH-1:0] n_since [NF];
    logic [TIME_WIDTH-1:0] n_es [NF];
    logic [TIME_WIDTH-1:0] n_xs [NF];
    phhd_pkg::t_fstate     n_agg;
    logic [TIME_WIDTH-1:0] n_agg_since;
    logic                  any_active;
    logic                  all_inactive;
    logic                  is_reject;

    assign o_pop     = i_valid && (!r_out_valid || !i_stall);
    assign use_prior = (i_cmd.outcome == phhd_pkg::OUT_REPLACE);
    assign is_reject = (i_cmd.outcome == phhd_pkg::OUT_REJECT);

    always_comb begin
        for (int f = 0; f < NF; f++) begin
            // Starting point: the live machine, or the saved one for a
            // replacement, wiped to unknown after a stale gap.
            if (i_cmd.stale) begin
                b_val[f]   = phhd_pkg::ST_UNKNOWN;
                b_since[f] = '0;
                b_es[f]    = '0;
                b_xs[f]    = '0;
            end else begin
                b_val[f]   = use_prior ? r_p_val[f]   : r_val[f];
                b_since[f] = use_prior ? r_p_since[f] : r_since[f];
                b_es[f]    = use_prior ? r_p_es[f]    : r_es[f];
                b_xs[f]    = use_prior ? r_p_xs[f]    : r_xs[f];
            end

            // One subtract and compare per facet serves whichever hold runs.
            act[f]  = (b_val[f] == phhd_pkg::ST_ACTIVE);
            run[f]  = act[f] ? b_xs[f] : b_es[f];
            st[f]   = (run[f] == '0) ? i_time : run[f];
            diff[f] = i_time - st[f];
            hold[f] = act[f] ? CMP_W'(i_exit_hold) : CMP_W'(i_enter_hold);
            hit[f]  = (CMP_W'(diff[f]) >= hold[f]);
            sum[f]  = CMP_W'(st[f]) + hold[f];

            n_val[f]   = b_val[f];
            n_since[f] = b_since[f];
            n_es[f]    = '0;
            n_xs[f]    = '0;
            if (act[f]) begin
                if (i_cmd.inside_exit[f]) begin
                    if (hit[f]) begin
                        n_val[f]   = phhd_pkg::ST_INACTIVE;
                        n_since[f] = sum[f][TIME_WIDTH-1:0];
                    end else begin
                        n_xs[f] = st[f];
                    end
                end
            end else if (i_cmd.beyond[f]) begin
                if (hit[f]) begin
                    n_val[f]   = phhd_pkg::ST_ACTIVE;
                    n_since[f] = sum[f][TIME_WIDTH-1:0];
                end else begin
                    n_es[f] = st[f];
                end
            end else if (b_val[f] != phhd_pkg::ST_INACTIVE) begin
                n_val[f]   = phhd_pkg::ST_INACTIVE;
                n_since[f] = i_time;
            end
        end

        if (i_cmd.stale) begin
            b_agg       = phhd_pkg::ST_UNKNOWN;
            b_agg_since = '0;
        end else begin
            b_agg       = use_prior ? r_p_agg       : r_agg;
            b_agg_since = use_prior ? r_p_agg_since : r_agg_since;
        end

        any_active   = 1'b0;
        all_inactive = 1'b1;
        for (int f = 0; f < NF; f++) begin
            any_active   = any_active | (n_val[f] == phhd_pkg::ST_ACTIVE);
            all_inactive = all_inactive & (n_val[f] == phhd_pkg::ST_INACTIVE);
        end
        if (any_active) begin
            n_agg = phhd_pkg::ST_ACTIVE;
        end else if (all_inactive) begin
            n_agg = phhd_pkg::ST_INACTIVE;
        end else begin
            n_agg = phhd_pkg::ST_UNKNOWN;
        end
        n_agg_since = (n_agg != b_agg) ? i_time : b_agg_since;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < NF; f++) begin
                r_val[f]     <= phhd_pkg::ST_UNKNOWN;
                r_since[f]   <= '0;
                r_es[f]      <= '0;
                r_xs[f]      <= '0;
                r_p_val[f]   <= phhd_pkg::ST_UNKNOWN;
                r_p_since[f] <= '0;
                r_p_es[f]    <= '0;
                r_p_xs[f]    <= '0;
            end
            r_agg         <= phhd_pkg::ST_UNKNOWN;
            r_agg_since   <= '0;
            r_p_agg       <= phhd_pkg::ST_UNKNOWN;
            r_p_agg_since <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop && !is_reject) begin
                for (int f = 0; f < NF; f++) begin
                    r_val[f]   <= n_val[f];
                    r_since[f] <= n_since[f];
                    r_es[f]    <= n_es[f];
                    r_xs[f]    <= n_xs[f];
                end
                r_agg       <= n_agg;
                r_agg_since <= n_agg_since;
                if (!use_prior) begin
                    for (int f = 0; f < NF; f++) begin
                        r_p_val[f]   <= r_val[f];
                        r_p_since[f] <= r_since[f];
                        r_p_es[f]    <= r_es[f];
                        r_p_xs[f]    <= r_xs[f];
                    end
                    r_p_agg       <= r_agg;
                    r_p_agg_since <= r_agg_since;
                end
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_outcome <= i_cmd.outcome;
            for (int f = 0; f < NF; f++) begin
                r_out_state[f] <= is_reject ? r_val[f]   : n_val[f];
                r_out_since[f] <= is_reject ? r_since[f] : n_since[f];
            end
            r_out_agg       <= is_reject ? r_agg       : n_agg;
            r_out_agg_since <= is_reject ? r_agg_since : n_agg_since;
            r_out_changed   <= !is_reject && (n_agg != r_agg);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_outcome   = r_out_outcome;
    assign o_state     = r_out_state;
    assign o_since     = r_out_since;
    assign o_agg       = r_out_agg;
    assign o_agg_since = r_out_agg_since;
    assign o_changed   = r_out_changed;

endmodule

`default_nettype wire

// ===== sv/posture_hysteresis_hold_detector.sv =====
// Posture hysteresis hold detector.
//
// Input channel: i_valid with the sample time and six condition flags; the
// block drives o_stall. An item is taken at a clock edge with i_valid high
// and o_stall low. Output channel: o_valid with the outcome, the three facet
// states, the aggregate state and their since times; the receiver drives
// i_stall, and a result is taken at an edge with o_valid high and i_stall low.
// The result of an item is registered twice: the queue holds it first, then
// the result register. Items are taken back to back, one per cycle, while
// o_stall is low: the front part classifies an item against its own copy of
// the last two sample times, a two-entry queue holds it, and the back part
// runs the three facet machines in combinational logic ahead of the result
// register, limited by one subtract, compare and add per facet on the time
// width. When the receiver stalls, the result register holds, the queue fills
// and o_stall rises once both entries are in use; no item is lost.
// Reset clears all facet state, the saved prior copy, the sample times and
// the queue, and loads the register defaults; there is no clearing pass.
// Configuration writes take effect at the edge of i_cfg_we and must be made
// only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module posture_hysteresis_hold_detector #(
    parameter int TIME_WIDTH = 63
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_index,
    input  wire [39:0]  i_cfg_data,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire [62:0]  i_sample_time,
    input  wire         i_body_beyond_enter,
    input  wire         i_body_inside_exit,
    input  wire         i_left_beyond_enter,
    input  wire         i_left_inside_exit,
    input  wire         i_right_beyond_enter,
    input  wire         i_right_inside_exit,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [1:0]  o_outcome,
    output logic [1:0]  o_body_state,
    output logic [1:0]  o_left_state,
    output logic [1:0]  o_right_state,
    output logic [1:0]  o_deviated_state,
    output logic [62:0] o_body_since,
    output logic [62:0] o_left_since,
    output logic [62:0] o_right_since,
    output logic [62:0] o_deviated_since,
    output logic        o_state_changed
);

    localparam int PW    = phhd_pkg::TIME_PORT_W;
    localparam int NF    = phhd_pkg::FACETS;
    localparam int CMD_W = $bits(phhd_pkg::t_cmd);
    localparam int QW    = TIME_WIDTH + CMD_W;

    // Configuration registers.
    logic [phhd_pkg::CFG_W-1:0] r_enter_hold;
    logic [phhd_pkg::CFG_W-1:0] r_exit_hold;
    logic [phhd_pkg::CFG_W-1:0] r_stale_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_hold    <= '0;
            r_exit_hold     <= '0;
            r_stale_timeout <= phhd_pkg::STALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                phhd_pkg::REG_ENTER_HOLD:    r_enter_hold    <= i_cfg_data;
                phhd_pkg::REG_EXIT_HOLD:     r_exit_hold     <= i_cfg_data;
                phhd_pkg::REG_STALE_TIMEOUT: r_stale_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The timestamp is taken modulo 2^TIME_WIDTH.
    logic [TIME_WIDTH-1:0] in_time;
    logic [NF-1:0]         in_beyond;
    logic [NF-1:0]         in_inside;

    assign in_time   = i_sample_time[TIME_WIDTH-1:0];
    assign in_beyond = {i_right_beyond_enter, i_left_beyond_enter, i_body_beyond_enter};
    assign in_inside = {i_right_inside_exit, i_left_inside_exit, i_body_inside_exit};

    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_valid;
    logic [QW-1:0]         q_data;
    logic [TIME_WIDTH-1:0] f_time;
    phhd_pkg::t_cmd        f_cmd;
    logic [TIME_WIDTH-1:0] h_time;
    phhd_pkg::t_cmd        h_cmd;

    assign o_stall = q_full;

    phhd_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_full          (q_full),
        .i_time          (in_time),
        .i_beyond        (in_beyond),
        .i_inside        (in_inside),
        .i_stale_timeout (r_stale_timeout),
        .o_push          (q_push),
        .o_time          (f_time),
        .o_cmd           (f_cmd)
    );

    phhd_queue #(
        .W     (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .i_data  ({f_time, f_cmd}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign h_time = q_data[CMD_W +: TIME_WIDTH];
    assign h_cmd  = phhd_pkg::t_cmd'(q_data[CMD_W-1:0]);

    phhd_pkg::t_outcome    b_outcome;
    phhd_pkg::t_fstate     b_state [NF];
    logic [TIME_WIDTH-1:0] b_since [NF];
    phhd_pkg::t_fstate     b_agg;
    logic [TIME_WIDTH-1:0] b_agg_since;

    phhd_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_time       (h_time),
        .i_cmd        (h_cmd),
        .i_enter_hold (r_enter_hold),
        .i_exit_hold  (r_exit_hold),
        .i_stall      (i_stall),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .o_outcome    (b_outcome),
        .o_state      (b_state),
        .o_since      (b_since),
        .o_agg        (b_agg),
        .o_agg_since  (b_agg_since),
        .o_changed    (o_state_changed)
    );

    assign o_outcome        = b_outcome;
    assign o_body_state     = b_state[0];
    assign o_left_state     = b_state[1];
    assign o_right_state    = b_state[2];
    assign o_deviated_state = b_agg;
    assign o_body_since     = PW'(b_since[0]);
    assign o_left_since     = PW'(b_since[1]);
    assign o_right_since    = PW'(b_since[2]);
    assign o_deviated_since = PW'(b_agg_since);

    // A rejected sample never moves the aggregate.
    a_reject_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome == phhd_pkg::OUT_REJECT)) |-> !o_state_changed)
        else $error("rejected sample reports an aggregate change");

    // The aggregate is active exactly when some facet is active.
    a_agg_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_deviated_state == phhd_pkg::ST_ACTIVE) ==
            ((o_body_state == phhd_pkg::ST_ACTIVE) ||
             (o_left_state == phhd_pkg::ST_ACTIVE) ||
             (o_right_state == phhd_pkg::ST_ACTIVE))))
        else $error("aggregate active does not match the facets");

    // An inactive aggregate needs all three facets inactive.
    a_agg_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_deviated_state == phhd_pkg::ST_INACTIVE)) |->
            ((o_body_state == phhd_pkg::ST_INACTIVE) &&
             (o_left_state == phhd_pkg::ST_INACTIVE) &&
             (o_right_state == phhd_pkg::ST_INACTIVE)))
        else $error("aggregate inactive while a facet is not inactive");

    // A queued item with a free result register is carried out at once.
    a_back_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !o_valid) |=> o_valid)
        else $error("back part failed to take a queued item");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // The spare register index: writes to it must leave the three real registers alone.
    localparam logic [phhd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [phhd_pkg::CFG_W-1:0]     HOLD_MAX   = '1;
    localparam logic [62:0]          TIME_MAX   = '1;
    localparam int                   RANDOM_PER_PHASE = 225;
    localparam int                   PHASES     = 6;

    // One input item as the sender holds it. Where typed is set, the outcome and the
    // aggregate state written in the row are what the block must show, whatever the
    // predictor says; the other fields still come from the predictor.
    // Flag bit 2f is "beyond enter" and bit 2f+1 is "inside exit" of facet f.
    typedef struct packed {
        logic [62:0]        t;
        logic [5:0]         flags;
        logic               typed;
        phhd_pkg::t_outcome want_outcome;
        phhd_pkg::t_fstate  want_dev;
    } t_sample;

    // The whole posture machine: three facets plus the aggregate.
    typedef struct packed {
        phhd_pkg::t_fstate [phhd_pkg::FACETS-1:0]  val;
        logic [phhd_pkg::FACETS-1:0][62:0]         since;
        logic [phhd_pkg::FACETS-1:0][62:0]         enter_st;
        logic [phhd_pkg::FACETS-1:0][62:0]         exit_st;
        phhd_pkg::t_fstate                         agg;
        logic [62:0]                               agg_since;
    } t_posture;

    // One result item as the block should show it.
    typedef struct packed {
        phhd_pkg::t_outcome outcome;
        phhd_pkg::t_fstate  body_st;
        phhd_pkg::t_fstate  left_st;
        phhd_pkg::t_fstate  right_st;
        phhd_pkg::t_fstate  dev_st;
        logic [62:0]        body_since;
        logic [62:0]        left_since;
        logic [62:0]        right_since;
        logic [62:0]        dev_since;
        logic               changed;
    } t_report;

    // Block ports. Every input has a known value from time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [39:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic [62:0] i_sample_time = '0;
    logic        i_body_beyond_enter = 1'b0;
    logic        i_body_inside_exit = 1'b0;
    logic        i_left_beyond_enter = 1'b0;
    logic        i_left_inside_exit = 1'b0;
    logic        i_right_beyond_enter = 1'b0;
    logic        i_right_inside_exit = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_outcome;
    logic [1:0]  o_body_state;
    logic [1:0]  o_left_state;
    logic [1:0]  o_right_state;
    logic [1:0]  o_deviated_state;
    logic [62:0] o_body_since;
    logic [62:0] o_left_since;
    logic [62:0] o_right_since;
    logic [62:0] o_deviated_since;
    logic        o_state_changed;

    // Predictor state: the live machine, the copy taken before the last append, the
    // time of the last appended sample and the one before it, and the registers.
    t_posture    live = '0;
    t_posture    saved = '0;
    logic [62:0] last_time_seen = '0;
    logic [62:0] saved_time = '0;
    logic [39:0] enter_reg = '0;
    logic [39:0] exit_reg = '0;
    logic [39:0] stale_reg = phhd_pkg::STALE_RESET;

    t_sample     samples_to_send[$];
    t_report     expected_reports[$];
    t_sample     on_port = '0;
    int          errors = 0;

    // Generator state: the newest time offered and the slow-moving posture of each
    // facet (1 means deviated), so that conditions persist long enough for holds.
    logic [62:0] gen_last = '0;
    logic [2:0]  posture_mode = '0;

    // Sender pacing and receiver pattern.
    int          tx_burst = 0;
    int          tx_gap = 0;
    int          rx_cycle = 0;
    int          rx_window = 0;
    int          rx_mode = 0;
    int          holdoff_left = 0;
    int          last_holdoff = -100000;

    // Directed opening under the reset register values (both holds zero, stale
    // timeout one second). Rows cover a zero time, the first sample with no gap
    // test, a replacement that redoes that sample from the state before it, an
    // earlier time, a held exit with zero hold, a gap just over the timeout, a gap
    // exactly at the timeout, and both flags set at once.
    t_sample opening [11] = '{
        '{63'd0,          6'b111111, 1'b1, phhd_pkg::OUT_REJECT,  phhd_pkg::ST_UNKNOWN},
        '{63'd100,        6'b010101, 1'b1, phhd_pkg::OUT_APPEND,  phhd_pkg::ST_ACTIVE},
        '{63'd100,        6'b000000, 1'b1, phhd_pkg::OUT_REPLACE, phhd_pkg::ST_INACTIVE},
        '{63'd50,         6'b111111, 1'b1, phhd_pkg::OUT_REJECT,  phhd_pkg::ST_INACTIVE},
        '{63'd200,        6'b000001, 1'b1, phhd_pkg::OUT_APPEND,  phhd_pkg::ST_ACTIVE},
        '{63'd300,        6'b000010, 1'b1, phhd_pkg::OUT_APPEND,  phhd_pkg::ST_INACTIVE},
        '{63'd1000000301, 6'b000100, 1'b1, phhd_pkg::OUT_APPEND,  phhd_pkg::ST_ACTIVE},
        '{63'd2000000301, 6'b000000, 1'b0, phhd_pkg::OUT_APPEND,  phhd_pkg::ST_UNKNOWN},
        '{63'd2000000301, 6'b001000, 1'b0, phhd_pkg::OUT_APPEND,  phhd_pkg::ST_UNKNOWN},
        '{63'd2000000302, 6'b101010, 1'b0, phhd_pkg::OUT_APPEND,  phhd_pkg::ST_UNKNOWN},
        '{63'd2000000303, 6'b111111, 1'b0, phhd_pkg::OUT_APPEND,  phhd_pkg::ST_UNKNOWN}
    };

    // Directed close, run with zero holds and the largest timeout. The largest time
    // is a huge gap, so the machine goes stale; the replacement redoes that step
    // from the saved copy; nothing can follow the largest time but rejects.
    t_sample closing [5] = '{
        '{TIME_MAX,         6'b010101, 1'b1, phhd_pkg::OUT_APPEND,  phhd_pkg::ST_ACTIVE},
        '{TIME_MAX,         6'b000000, 1'b1, phhd_pkg::OUT_REPLACE, phhd_pkg::ST_INACTIVE},
        '{TIME_MAX - 63'd1, 6'b111111, 1'b1, phhd_pkg::OUT_REJECT,  phhd_pkg::ST_INACTIVE},
        '{63'd0,            6'b101010, 1'b1, phhd_pkg::OUT_REJECT,  phhd_pkg::ST_INACTIVE},
        '{63'h4000000000000000, 6'b010101, 1'b1, phhd_pkg::OUT_REJECT,
          phhd_pkg::ST_INACTIVE}
    };

    posture_hysteresis_hold_detector u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_sample_time       (i_sample_time),
        .i_body_beyond_enter (i_body_beyond_enter),
        .i_body_inside_exit  (i_body_inside_exit),
        .i_left_beyond_enter (i_left_beyond_enter),
        .i_left_inside_exit  (i_left_inside_exit),
        .i_right_beyond_enter(i_right_beyond_enter),
        .i_right_inside_exit (i_right_inside_exit),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_outcome           (o_outcome),
        .o_body_state        (o_body_state),
        .o_left_state        (o_left_state),
        .o_right_state       (o_right_state),
        .o_deviated_state    (o_deviated_state),
        .o_body_since        (o_body_since),
        .o_left_since        (o_left_since),
        .o_right_since       (o_right_since),
        .o_deviated_since    (o_deviated_since),
        .o_state_changed     (o_state_changed)
    );

    always #5 i_clk = ~i_clk;

    // One step of the posture machine for a sample at time t, where prev is the time
    // of the sample before it (zero when there is none, which skips the gap test).
    // Time differences are taken one bit wider so that they compare as unsigned.
    function automatic t_posture advance(t_posture m, logic [5:0] fl, logic [62:0] t,
                                         logic [62:0] prev);
        int                f;
        logic              over_enter;
        logic              under_exit;
        phhd_pkg::t_fstate agg;
        if (prev != '0 && ({1'b0, t} - {1'b0, prev}) > {24'd0, stale_reg})
            m = '0;
        for (f = 0; f < phhd_pkg::FACETS; f++) begin
            over_enter = fl[2*f];
            under_exit = fl[2*f+1];
            if (m.val[f] == phhd_pkg::ST_ACTIVE) begin
                m.enter_st[f] = '0;
                if (under_exit) begin
                    if (m.exit_st[f] == '0)
                        m.exit_st[f] = t;
                    if (({1'b0, t} - {1'b0, m.exit_st[f]}) >= {24'd0, exit_reg}) begin
                        // Backdated to the moment the hold was satisfied.
                        m.val[f]     = phhd_pkg::ST_INACTIVE;
                        m.since[f]   = m.exit_st[f] + {23'd0, exit_reg};
                        m.exit_st[f] = '0;
                    end
                end else begin
                    m.exit_st[f] = '0;
                end
            end else begin
                m.exit_st[f] = '0;
                if (over_enter) begin
                    if (m.enter_st[f] == '0)
                        m.enter_st[f] = t;
                    if (({1'b0, t} - {1'b0, m.enter_st[f]}) >= {24'd0, enter_reg}) begin
                        m.val[f]      = phhd_pkg::ST_ACTIVE;
                        m.since[f]    = m.enter_st[f] + {23'd0, enter_reg};
                        m.enter_st[f] = '0;
                    end
                end else begin
                    // Not deviated: an unknown facet settles at once, no hold.
                    m.enter_st[f] = '0;
                    if (m.val[f] != phhd_pkg::ST_INACTIVE) begin
                        m.val[f]   = phhd_pkg::ST_INACTIVE;
                        m.since[f] = t;
                    end
                end
            end
        end
        if (m.val[0] == phhd_pkg::ST_ACTIVE || m.val[1] == phhd_pkg::ST_ACTIVE ||
            m.val[2] == phhd_pkg::ST_ACTIVE)
            agg = phhd_pkg::ST_ACTIVE;
        else if (m.val[0] == phhd_pkg::ST_INACTIVE && m.val[1] == phhd_pkg::ST_INACTIVE &&
                 m.val[2] == phhd_pkg::ST_INACTIVE)
            agg = phhd_pkg::ST_INACTIVE;
        else
            agg = phhd_pkg::ST_UNKNOWN;
        if (agg != m.agg) begin
            m.agg       = agg;
            m.agg_since = t;
        end
        return m;
    endfunction

    // Classifies an accepted sample, updates the predictor and queues its result.
    task automatic posture_predict(t_sample s);
        t_report           r;
        phhd_pkg::t_fstate was;
        was = live.agg;
        if (s.t == '0 || s.t < last_time_seen) begin
            r.outcome = phhd_pkg::OUT_REJECT;
        end else if (s.t == last_time_seen) begin
            // Same time as the last sample: redo that step from the saved copy.
            live      = advance(saved, s.flags, s.t, saved_time);
            r.outcome = phhd_pkg::OUT_REPLACE;
        end else begin
            saved          = live;
            saved_time     = last_time_seen;
            live           = advance(live, s.flags, s.t, last_time_seen);
            last_time_seen = s.t;
            r.outcome      = phhd_pkg::OUT_APPEND;
        end
        r.body_st     = live.val[0];
        r.left_st     = live.val[1];
        r.right_st    = live.val[2];
        r.dev_st      = live.agg;
        r.body_since  = live.since[0];
        r.left_since  = live.since[1];
        r.right_since = live.since[2];
        r.dev_since   = live.agg_since;
        r.changed     = (r.outcome != phhd_pkg::OUT_REJECT) && (live.agg != was);
        if (s.typed) begin
            r.outcome = s.want_outcome;
            r.dev_st  = s.want_dev;
        end
        expected_reports.insert(expected_reports.size(), r);
    endtask

    task automatic check_field(string what, logic [62:0] want, logic [62:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    function automatic logic [63:0] rand_below(logic [63:0] n);
        return {$urandom, $urandom} % n;
    endfunction

    function automatic void offer(t_sample s);
        if (s.t > gen_last)
            gen_last = s.t;
        samples_to_send.insert(samples_to_send.size(), s);
    endfunction

    // Random samples: mostly a forward-moving timeline with steps up to dmax and
    // facets whose posture changes only now and then, so that holds get completed
    // and broken; mixed in are zero and earlier times, equal times, gaps just over
    // and exactly at the stale timeout, and items with random flags.
    task automatic queue_random(int count, logic [63:0] dmax);
        t_sample s;
        int      n;
        int      r;
        int      f;
        for (n = 0; n < count; n++) begin
            s = '0;
            r = $urandom_range(0, 99);
            if (r < 2)
                s.t = '0;
            else if (r < 6)
                s.t = (gen_last == '0) ? 63'd0 : 63'(rand_below({1'b0, gen_last}));
            else if (r < 14)
                s.t = gen_last;
            else if (r < 17)
                s.t = gen_last + {23'd0, stale_reg} + 63'd1 + 63'(rand_below(64'd1000));
            else if (r < 19)
                s.t = gen_last + {23'd0, stale_reg};
            else
                s.t = gen_last + 63'd1 + 63'(rand_below(dmax));
            if ($urandom_range(0, 9) == 0) begin
                s.flags = 6'($urandom);
            end else begin
                for (f = 0; f < phhd_pkg::FACETS; f++) begin
                    if ($urandom_range(0, 11) == 0)
                        posture_mode[f] = ~posture_mode[f];
                    s.flags[2*f]   = posture_mode[f] ? ($urandom_range(0, 15) != 0)
                                                     : ($urandom_range(0, 15) == 0);
                    s.flags[2*f+1] = posture_mode[f] ? ($urandom_range(0, 15) == 0)
                                                     : ($urandom_range(0, 15) != 0);
                end
            end
            offer(s);
        end
    endtask

    // Register write: the new value counts from the edge with the write enable high.
    task automatic write_reg(logic [phhd_pkg::CFG_IDX_W-1:0] idx,
                             logic [phhd_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            phhd_pkg::REG_ENTER_HOLD:    enter_reg = val;
            phhd_pkg::REG_EXIT_HOLD:     exit_reg = val;
            phhd_pkg::REG_STALE_TIMEOUT: stale_reg = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Every item yields exactly one result, so the block is idle once nothing is
    // left to send and no result is outstanding; it then waits on for margin.
    task automatic wait_drained();
        while (samples_to_send.size() != 0 || i_valid || expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Sender: the input side is sampled at the edge, before the block updates, so an
    // item counts as accepted exactly when the block took it. A stalled item stays on
    // the port unchanged; otherwise the next one goes out unless a gap is running.
    always @(posedge i_clk) begin
        logic nvalid;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                posture_predict(on_port);
            if (!(i_valid && o_stall)) begin
                nvalid = 1'b0;
                if (tx_gap != 0) begin
                    tx_gap--;
                end else if (samples_to_send.size() != 0) begin
                    on_port = samples_to_send.pop_front();
                    nvalid  = 1'b1;
                    i_sample_time        <= on_port.t;
                    i_body_beyond_enter  <= on_port.flags[0];
                    i_body_inside_exit   <= on_port.flags[1];
                    i_left_beyond_enter  <= on_port.flags[2];
                    i_left_inside_exit   <= on_port.flags[3];
                    i_right_beyond_enter <= on_port.flags[4];
                    i_right_inside_exit  <= on_port.flags[5];
                    if (tx_burst != 0) begin
                        tx_burst--;
                    end else begin
                        // End of a burst: a third of the time it runs straight on.
                        tx_burst = $urandom_range(1, 16);
                        tx_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                i_valid <= nvalid;
            end
        end
    end

    // Receiver: checks each accepted result against the oldest expectation, then
    // picks its stall for the next cycle. The pattern changes in windows of random
    // length (never, light, heavy, alternating). Once in a while, with over 100
    // items waiting at the sender, it holds off for a long stretch so that the
    // block's queue fills and its input stalls.
    always @(posedge i_clk) begin
        t_report want;
        logic    nstall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result item with none expected, outcome %0d",
                             $time, o_outcome);
                    errors++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("outcome",        63'(want.outcome),  63'(o_outcome));
                    check_field("body_state",     63'(want.body_st),  63'(o_body_state));
                    check_field("left_state",     63'(want.left_st),  63'(o_left_state));
                    check_field("right_state",    63'(want.right_st), 63'(o_right_state));
                    check_field("deviated_state", 63'(want.dev_st),
                                63'(o_deviated_state));
                    check_field("body_since",     want.body_since,  o_body_since);
                    check_field("left_since",     want.left_since,  o_left_since);
                    check_field("right_since",    want.right_since, o_right_since);
                    check_field("deviated_since", want.dev_since,   o_deviated_since);
                    check_field("state_changed",  63'(want.changed),
                                63'(o_state_changed));
                end
            end
            rx_cycle++;
            if (holdoff_left != 0) begin
                holdoff_left--;
                nstall = 1'b1;
            end else if (rx_cycle - last_holdoff > 1500 && samples_to_send.size() > 100) begin
                holdoff_left = 60;
                last_holdoff = rx_cycle;
                nstall       = 1'b1;
            end else begin
                if (rx_window == 0) begin
                    rx_window = $urandom_range(16, 96);
                    rx_mode   = $urandom_range(0, 3);
                end else begin
                    rx_window--;
                end
                case (rx_mode)
                    0:       nstall = 1'b0;
                    1:       nstall = ($urandom_range(0, 3) == 0);
                    2:       nstall = ($urandom_range(0, 3) != 0);
                    default: nstall = rx_cycle[0];
                endcase
            end
            i_stall <= nstall;
        end
    end

    // Main sequence: reset, then six phases of register settings, each with random
    // samples (the first one opens with the directed rows), then the directed close.
    initial begin
        int          p;
        int          n;
        logic [39:0] eh;
        logic [39:0] xh;
        logic [39:0] st;
        logic [63:0] dmax;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    eh = '0; xh = '0; st = phhd_pkg::STALE_RESET; dmax = 64'd400000000;
                end
                1: begin eh = 40'd1000; xh = 40'd500;  st = 40'd5000;    dmax = 64'd400;       end
                2: begin eh = 40'd7;    xh = 40'd3;    st = 40'd1;       dmax = 64'd1;         end
                3: begin eh = HOLD_MAX; xh = HOLD_MAX; st = HOLD_MAX;    dmax = 64'd1 << 38;   end
                4: begin eh = '0;       xh = 40'd12345; st = 40'd100000; dmax = 64'd5000;      end
                default: begin
                    eh   = 40'($urandom_range(0, 1000000));
                    xh   = 40'($urandom_range(0, 1000000));
                    dmax = 64'(((eh > xh) ? eh : xh) / 3 + 1);
                    st   = 40'(dmax * $urandom_range(1, 8));
                end
            endcase
            if (p == 0) begin
                @(negedge i_clk);
                for (n = 0; n < 11; n++)
                    offer(opening[n]);
            end else begin
                wait_drained();
                write_reg(phhd_pkg::REG_ENTER_HOLD, eh);
                write_reg(phhd_pkg::REG_EXIT_HOLD, xh);
                write_reg(phhd_pkg::REG_STALE_TIMEOUT, st);
                if (p == 4)
                    write_reg(REG_UNUSED, 40'({$urandom, $urandom}));
                @(negedge i_clk);
            end
            queue_random(RANDOM_PER_PHASE, dmax);
        end
        wait_drained();
        write_reg(phhd_pkg::REG_ENTER_HOLD, '0);
        write_reg(phhd_pkg::REG_EXIT_HOLD, '0);
        write_reg(phhd_pkg::REG_STALE_TIMEOUT, HOLD_MAX);
        @(negedge i_clk);
        for (n = 0; n < 5; n++)
            offer(closing[n]);
        wait_drained();
        repeat (8) @(negedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this stimulus.
    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
